// ===== design/dbc_pkg.sv =====
// Package for the definition chunker: beat types, scanner state codes and
// character constants. Used by dbc_scan and def_block_chunker.
package dbc_pkg;

   // Default widths of the scanner's counters.
   localparam int DEPTH_BITS_DEF  = 16;
   localparam int OFFSET_BITS_DEF = 32;
   localparam int LINE_BITS_DEF   = 24;

   // Characters the scanner looks for.
   localparam logic [7:0]  CHAR_OPEN  = 8'h7B;   // '{'
   localparam logic [7:0]  CHAR_CLOSE = 8'h7D;   // '}'
   localparam logic [7:0]  CHAR_NL    = 8'h0A;   // newline
   localparam logic [7:0]  CHAR_SPACE = 8'h20;   // ' '
   localparam logic [23:0] KEY_DEF    = 24'h646566;   // "def"

   // Result kinds.
   localparam logic [1:0] KIND_CHUNK      = 2'd0;
   localparam logic [1:0] KIND_NO_OPEN    = 2'd1;
   localparam logic [1:0] KIND_UNCLOSED   = 2'd2;

   // Scanner mode.
   typedef enum logic [1:0] {
      MODE_OUTSIDE,
      MODE_WAIT,
      MODE_BLOCK
   } scan_mode_type;

   // One input beat.
   typedef struct packed {
      logic [7:0] source_byte;
      logic       end_of_file;
   } req_item_type;

   // One result beat.
   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] start_offset;
      logic [23:0] start_line;
      logic [23:0] end_line;
      logic [23:0] end_column;
      logic [31:0] chunk_length;
   } rsp_item_type;

endpackage

// ===== design/dbc_scan.sv =====
// Scanner core of the definition chunker: position counters, keyword match
// and brace depth. Processes one byte per step; depends on dbc_pkg.
module dbc_scan #(
   parameter int DEPTH_BITS  = dbc_pkg::DEPTH_BITS_DEF,
   parameter int OFFSET_BITS = dbc_pkg::OFFSET_BITS_DEF,
   parameter int LINE_BITS   = dbc_pkg::LINE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  dbc_pkg::req_item_type item,
   output logic                  res_valid,
   output dbc_pkg::rsp_item_type res
);

   dbc_pkg::scan_mode_type mode_ff, mode_in;
   logic [31:0]            recent_ff, recent_in;
   logic [2:0]             bss_ff, bss_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [LINE_BITS-1:0]   col_ff, col_in;
   logic [DEPTH_BITS-1:0]  depth_ff, depth_in;
   logic [OFFSET_BITS-1:0] cs_offset_ff, cs_offset_in;
   logic [LINE_BITS-1:0]   cs_line_ff, cs_line_in;

   logic [7:0]             b;
   logic [DEPTH_BITS-1:0]  depth_dec;
   logic                   closed;
   logic                   at_start;
   logic                   after_nl;
   logic [OFFSET_BITS-1:0] length;

   assign b = item.source_byte;

   // State registers; they move only when a byte is stepped through.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= dbc_pkg::MODE_OUTSIDE;
         recent_ff    <= '0;
         bss_ff       <= '0;
         offset_ff    <= '0;
         line_ff      <= LINE_BITS'(1);
         col_ff       <= LINE_BITS'(1);
         depth_ff     <= '0;
         cs_offset_ff <= '0;
         cs_line_ff   <= LINE_BITS'(1);
      end else if (step) begin
         mode_ff      <= mode_in;
         recent_ff    <= recent_in;
         bss_ff       <= bss_in;
         offset_ff    <= offset_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         depth_ff     <= depth_in;
         cs_offset_ff <= cs_offset_in;
         cs_line_ff   <= cs_line_in;
      end
   end

   // Next state and result for the current byte.
   always_comb begin
      mode_in      = mode_ff;
      recent_in    = {recent_ff[23:0], b};
      bss_in       = bss_ff;
      depth_in     = depth_ff;
      cs_offset_in = cs_offset_ff;
      cs_line_in   = cs_line_ff;
      closed       = 1'b0;
      depth_dec    = (depth_ff == '0) ? '0 : depth_ff - DEPTH_BITS'(1);
      at_start     = (offset_ff == OFFSET_BITS'(3)) && (bss_ff >= 3'd3);
      after_nl     = (bss_ff >= 3'd4) && (recent_ff[31:24] == dbc_pkg::CHAR_NL);

      // Position counters saturate at their maximum.
      offset_in = (offset_ff == '1) ? offset_ff : offset_ff + OFFSET_BITS'(1);
      if (b == dbc_pkg::CHAR_NL) begin
         line_in = (line_ff == '1) ? line_ff : line_ff + LINE_BITS'(1);
         col_in  = LINE_BITS'(1);
      end else begin
         line_in = line_ff;
         col_in  = (col_ff == '1) ? col_ff : col_ff + LINE_BITS'(1);
      end

      case (mode_ff)
         dbc_pkg::MODE_WAIT: begin
            if (b == dbc_pkg::CHAR_OPEN) begin
               mode_in  = dbc_pkg::MODE_BLOCK;
               depth_in = DEPTH_BITS'(1);
            end
         end
         dbc_pkg::MODE_BLOCK: begin
            if (b == dbc_pkg::CHAR_OPEN) begin
               depth_in = (depth_ff == '1) ? depth_ff : depth_ff + DEPTH_BITS'(1);
            end else if (b == dbc_pkg::CHAR_CLOSE) begin
               depth_in = depth_dec;
               closed   = (depth_dec == '0);
            end
         end
         default: begin
            // Outside a block: a space after "def" at file start or after a newline.
            if (b == dbc_pkg::CHAR_SPACE && recent_ff[23:0] == dbc_pkg::KEY_DEF &&
                (at_start || after_nl)) begin
               mode_in      = dbc_pkg::MODE_WAIT;
               cs_offset_in = offset_ff - OFFSET_BITS'(3);
               cs_line_in   = line_ff;
               bss_in       = '0;
            end else begin
               bss_in = (bss_ff == 3'd7) ? bss_ff : bss_ff + 3'd1;
            end
         end
      endcase

      // Result fields come from the state after this byte.
      length           = offset_in - cs_offset_in;
      res.result_kind  = dbc_pkg::KIND_CHUNK;
      res.start_offset = 32'(cs_offset_in);
      res.start_line   = 24'(cs_line_in);
      res.end_line     = 24'(line_in);
      res.end_column   = 24'(col_in);
      res.chunk_length = closed ? 32'(length) : '0;
      res_valid        = closed;

      if (closed) begin
         mode_in  = dbc_pkg::MODE_OUTSIDE;
         bss_in   = '0;
         depth_in = '0;
      end

      // End of file: report a pending definition, then start a new file.
      if (item.end_of_file) begin
         if (!closed && mode_in == dbc_pkg::MODE_WAIT) begin
            res.result_kind = dbc_pkg::KIND_NO_OPEN;
            res_valid       = 1'b1;
         end else if (!closed && mode_in == dbc_pkg::MODE_BLOCK) begin
            res.result_kind = dbc_pkg::KIND_UNCLOSED;
            res_valid       = 1'b1;
         end
         mode_in      = dbc_pkg::MODE_OUTSIDE;
         recent_in    = '0;
         bss_in       = '0;
         offset_in    = '0;
         line_in      = LINE_BITS'(1);
         col_in       = LINE_BITS'(1);
         depth_in     = '0;
         cs_offset_in = '0;
         cs_line_in   = LINE_BITS'(1);
      end
   end

endmodule

// ===== design/def_block_chunker.sv =====
// Top level of the definition chunker: input register, scanner core and
// result register. Depends on dbc_pkg and dbc_scan.
//
// The block takes one source byte per cycle while the input is not stalled
// and finds top-level "def " definitions, reporting each chunk once its
// braces balance, and an error at end of file if a definition is still
// waiting for '{' or still open. A byte is held in an input register and
// passes the scanner while it advances; its result (if any) is then
// captured in the result register. Sustained throughput is one byte per
// cycle while the receiver does not stall, as the position and depth
// counters are updated for each byte as it advances. The input stalls only
// while the result register holds a beat that the receiver is stalling.
module def_block_chunker #(
   parameter int DEPTH_BITS  = dbc_pkg::DEPTH_BITS_DEF,
   parameter int OFFSET_BITS = dbc_pkg::OFFSET_BITS_DEF,
   parameter int LINE_BITS   = dbc_pkg::LINE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dbc_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dbc_pkg::rsp_item_type rsp_data
);

   logic                  in_valid_ff;
   dbc_pkg::req_item_type in_item_ff;
   logic                  out_valid_ff;
   dbc_pkg::rsp_item_type out_item_ff;
   logic                  advance;
   logic                  res_valid;
   dbc_pkg::rsp_item_type res;

   // A held byte moves on when the result register is free or being emptied.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff <= req_data;
      end
   end

   dbc_scan #(
      .DEPTH_BITS  (DEPTH_BITS),
      .OFFSET_BITS (OFFSET_BITS),
      .LINE_BITS   (LINE_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (in_item_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= res_valid;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_item_ff <= res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

endmodule
